// ===== sv/i2cra_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register access master package
// Phase codes, operation codes and the words passed between the front
// end, the back end and the result channel.
// ----------------------------------------------------------------------------
package i2cra_pkg;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_RS_PRE   = 4'd1,
      PH_ST_SETUP = 4'd2,
      PH_ST_HOLD  = 4'd3,
      PH_ST_LOW   = 4'd4,
      PH_TX_LOW   = 4'd5,
      PH_TX_HIGH  = 4'd6,
      PH_ACK_LOW  = 4'd7,
      PH_ACK_HIGH = 4'd8,
      PH_RX_LOW   = 4'd9,
      PH_RX_HIGH  = 4'd10,
      PH_MN_LOW   = 4'd11,
      PH_MN_HIGH  = 4'd12,
      PH_SP_LOW   = 4'd13,
      PH_SP_HIGH  = 4'd14,
      PH_SP_END   = 4'd15
   } phase_type;

   typedef enum logic [1:0] {
      STEP_ADDR  = 2'd0,
      STEP_REG   = 2'd1,
      STEP_DATA  = 2'd2,
      STEP_RADDR = 2'd3
   } byte_step_type;

   // Classified input word as held in the queue.
   typedef struct packed {
      logic       is_cmd;
      logic       is_read;
      logic [6:0] device_address;
      logic [7:0] register_address;
      logic [7:0] write_data;
      logic       sda_in;
   } item_type;

   // Queue head as seen by the back end.
   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_drive_enable;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       nack_seen;
      logic       command_rejected;
   } result_type;

endpackage

// ===== sv/i2cra_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register access master channels
// Command channel and result channel, each with valid and ready.
// ----------------------------------------------------------------------------
interface i2cra_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [6:0] device_address;
   logic [7:0] register_address;
   logic [7:0] write_data;
   logic       sda_in;

   modport source (output valid, operation, device_address, register_address,
                   write_data, sda_in, input ready);
   modport sink   (input valid, operation, device_address, register_address,
                   write_data, sda_in, output ready);
endinterface

interface i2cra_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_level;
   logic       sda_drive_enable;
   logic       busy_res;
   logic       done_res;
   logic [7:0] read_data;
   logic       nack_seen;
   logic       command_rejected;

   modport source (output valid, scl_level, sda_level, sda_drive_enable, busy_res,
                   done_res, read_data, nack_seen, command_rejected, input ready);
   modport sink   (input valid, scl_level, sda_level, sda_drive_enable, busy_res,
                   done_res, read_data, nack_seen, command_rejected, output ready);
endinterface

// ===== sv/i2c_register_access_master.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register access master
// Runs whole I2C register write and read transactions at pin level.
// ----------------------------------------------------------------------------
// Each word on req_chan is one tick of the bus sequencer: a plain tick, or a
// command that starts a register write or read when the master is idle. For
// every accepted word exactly one word appears on rsp_chan, carrying the SCL
// and SDA levels, the SDA drive enable, busy, done, the last read byte, the
// NACK flag and whether a command was rejected.
// A word passes a two-entry queue and then the sequencer, which registers
// its result in the output register for rsp_chan. The sequencer takes one word
// per cycle while that register is free or being taken, so one word per cycle
// is sustained when rsp_chan keeps ready high.
// If rsp_chan stalls, the result stays in the output register, the queue
// fills and req_chan.ready drops once both entries are taken.
// csr_we writes ticks_per_phase (phase length in ticks, zero acts as one);
// write it only while idle. Reset empties the queue, returns the sequencer
// to idle with the bus released high and sets ticks_per_phase to one.
// ----------------------------------------------------------------------------
module i2c_register_access_master #(
   parameter int DIV_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   i2cra_req_if.sink   req_chan,
   i2cra_rsp_if.source rsp_chan,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   logic [15:0]         tpp_ff;
   logic                pop;
   i2cra_pkg::head_type head;

   always_ff @(posedge clock) begin
      if (reset) begin
         tpp_ff <= 16'd1;
      end else if (csr_we) begin
         tpp_ff <= csr_wdata;
      end
   end

   i2cra_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .pop      (pop),
      .head     (head)
   );

   i2cra_back #(
      .DIV_WIDTH (DIV_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .ticks_per_phase (tpp_ff),
      .head            (head),
      .pop             (pop),
      .rsp_chan        (rsp_chan)
   );

endmodule

// ===== sv/i2cra_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register access master front end
// Accepts command words, classifies the operation and holds them in a
// two-entry queue for the sequencer.
// ----------------------------------------------------------------------------
module i2cra_front (
   input  logic                clock,
   input  logic                reset,
   i2cra_req_if.sink           req_chan,
   input  logic                pop,
   output i2cra_pkg::head_type head
);

   i2cra_pkg::item_type mem_ff [2];
   i2cra_pkg::item_type item_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign req_chan.ready = (count_ff != 2'd2);
   assign push = req_chan.valid && req_chan.ready;

   always_comb begin
      item_in.is_cmd = (req_chan.operation == i2cra_pkg::OP_WRITE) ||
                       (req_chan.operation == i2cra_pkg::OP_READ);
      item_in.is_read = (req_chan.operation == i2cra_pkg::OP_READ);
      item_in.device_address = req_chan.device_address;
      item_in.register_address = req_chan.register_address;
      item_in.write_data = req_chan.write_data;
      item_in.sda_in = req_chan.sda_in;
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.item = mem_ff[rd_ptr_ff];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != 2'd0) else $error("queue popped while empty");
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |-> !req_chan.ready) else $error("queue accepted while full");

endmodule

// ===== sv/i2cra_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register access master back end
// Pin-level transaction sequencer, one queued word per step, with the
// result word held in an output register.
// ----------------------------------------------------------------------------
module i2cra_back #(
   parameter int DIV_WIDTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [15:0]         ticks_per_phase,
   input  i2cra_pkg::head_type head,
   output logic                pop,
   i2cra_rsp_if.source         rsp_chan
);

   localparam int LimW = (DIV_WIDTH < 16) ? DIV_WIDTH : 16;

   i2cra_pkg::phase_type     phase_ff, phase_in;
   i2cra_pkg::byte_step_type step_ff, step_in;
   logic [3:0]           bit_index_ff, bit_index_in;
   logic [7:0]           shift_ff, shift_in;
   logic [DIV_WIDTH-1:0] ticks_ff, ticks_in;
   logic [DIV_WIDTH-1:0] limit;
   logic                 is_read_ff, is_read_in;
   logic [6:0]           addr_ff, addr_in;
   logic [7:0]           reg_ff, reg_in;
   logic [7:0]           data_ff, data_in;
   logic [7:0]           rx_ff, rx_in;
   logic                 nack_ff, nack_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   i2cra_pkg::result_type res_ff, res_in;
   logic                 done;
   logic                 sda;
   logic [2:0]           pins;

   assign limit = DIV_WIDTH'(ticks_per_phase[LimW-1:0]);
   assign pop = head.valid && (!rsp_valid_ff || rsp_chan.ready);
   assign sda = head.item.sda_in;

   always_comb begin
      phase_in = phase_ff;
      step_in = step_ff;
      bit_index_in = bit_index_ff;
      shift_in = shift_ff;
      ticks_in = ticks_ff;
      is_read_in = is_read_ff;
      addr_in = addr_ff;
      reg_in = reg_ff;
      data_in = data_ff;
      rx_in = rx_ff;
      nack_in = nack_ff;
      done = 1'b0;
      if (phase_ff == i2cra_pkg::PH_IDLE) begin
         if (head.item.is_cmd) begin
            addr_in = head.item.device_address;
            reg_in = head.item.register_address;
            data_in = head.item.write_data;
            is_read_in = head.item.is_read;
            step_in = i2cra_pkg::STEP_ADDR;
            bit_index_in = 4'd0;
            nack_in = 1'b0;
            ticks_in = '0;
            phase_in = i2cra_pkg::PH_ST_SETUP;
         end
      end else begin
         ticks_in = ticks_ff + DIV_WIDTH'(1);
         if (ticks_in >= limit || ticks_in == '0) begin
            ticks_in = '0;
            unique case (phase_ff)
               i2cra_pkg::PH_RS_PRE:   phase_in = i2cra_pkg::PH_ST_SETUP;
               i2cra_pkg::PH_ST_SETUP: phase_in = i2cra_pkg::PH_ST_HOLD;
               i2cra_pkg::PH_ST_HOLD:  phase_in = i2cra_pkg::PH_ST_LOW;
               i2cra_pkg::PH_ST_LOW: begin
                  shift_in = {addr_ff, step_ff == i2cra_pkg::STEP_RADDR};
                  bit_index_in = 4'd0;
                  phase_in = i2cra_pkg::PH_TX_LOW;
               end
               i2cra_pkg::PH_TX_LOW:   phase_in = i2cra_pkg::PH_TX_HIGH;
               i2cra_pkg::PH_TX_HIGH: begin
                  shift_in = {shift_ff[6:0], 1'b0};
                  bit_index_in = bit_index_ff + 4'd1;
                  phase_in = (bit_index_in >= 4'd8) ? i2cra_pkg::PH_ACK_LOW
                                                    : i2cra_pkg::PH_TX_LOW;
               end
               i2cra_pkg::PH_ACK_LOW:  phase_in = i2cra_pkg::PH_ACK_HIGH;
               i2cra_pkg::PH_ACK_HIGH: begin
                  if (sda) begin
                     nack_in = 1'b1;
                  end
                  bit_index_in = 4'd0;
                  if (step_ff == i2cra_pkg::STEP_ADDR) begin
                     step_in = i2cra_pkg::STEP_REG;
                     shift_in = reg_ff;
                     phase_in = i2cra_pkg::PH_TX_LOW;
                  end else if (step_ff == i2cra_pkg::STEP_REG && !is_read_ff) begin
                     step_in = i2cra_pkg::STEP_DATA;
                     shift_in = data_ff;
                     phase_in = i2cra_pkg::PH_TX_LOW;
                  end else if (step_ff == i2cra_pkg::STEP_REG) begin
                     step_in = i2cra_pkg::STEP_RADDR;
                     phase_in = i2cra_pkg::PH_RS_PRE;
                  end else if (step_ff == i2cra_pkg::STEP_RADDR) begin
                     shift_in = 8'd0;
                     phase_in = i2cra_pkg::PH_RX_LOW;
                  end else begin
                     phase_in = i2cra_pkg::PH_SP_LOW;
                  end
               end
               i2cra_pkg::PH_RX_LOW:   phase_in = i2cra_pkg::PH_RX_HIGH;
               i2cra_pkg::PH_RX_HIGH: begin
                  shift_in = {shift_ff[6:0], sda};
                  bit_index_in = bit_index_ff + 4'd1;
                  if (bit_index_in >= 4'd8) begin
                     rx_in = shift_in;
                     phase_in = i2cra_pkg::PH_MN_LOW;
                  end else begin
                     phase_in = i2cra_pkg::PH_RX_LOW;
                  end
               end
               i2cra_pkg::PH_MN_LOW:   phase_in = i2cra_pkg::PH_MN_HIGH;
               i2cra_pkg::PH_MN_HIGH:  phase_in = i2cra_pkg::PH_SP_LOW;
               i2cra_pkg::PH_SP_LOW:   phase_in = i2cra_pkg::PH_SP_HIGH;
               i2cra_pkg::PH_SP_HIGH:  phase_in = i2cra_pkg::PH_SP_END;
               i2cra_pkg::PH_SP_END: begin
                  phase_in = i2cra_pkg::PH_IDLE;
                  done = 1'b1;
               end
               default:                phase_in = i2cra_pkg::PH_IDLE;
            endcase
         end
      end

      // Pin order is drive, sda, scl.
      unique case (phase_in)
         i2cra_pkg::PH_RS_PRE:   pins = 3'b110;
         i2cra_pkg::PH_ST_SETUP: pins = 3'b111;
         i2cra_pkg::PH_ST_HOLD:  pins = 3'b101;
         i2cra_pkg::PH_ST_LOW:   pins = 3'b100;
         i2cra_pkg::PH_TX_LOW:   pins = {1'b1, shift_in[7], 1'b0};
         i2cra_pkg::PH_TX_HIGH:  pins = {1'b1, shift_in[7], 1'b1};
         i2cra_pkg::PH_ACK_LOW:  pins = 3'b010;
         i2cra_pkg::PH_ACK_HIGH: pins = 3'b011;
         i2cra_pkg::PH_RX_LOW:   pins = 3'b010;
         i2cra_pkg::PH_RX_HIGH:  pins = 3'b011;
         i2cra_pkg::PH_MN_LOW:   pins = 3'b110;
         i2cra_pkg::PH_MN_HIGH:  pins = 3'b111;
         i2cra_pkg::PH_SP_LOW:   pins = 3'b100;
         i2cra_pkg::PH_SP_HIGH:  pins = 3'b101;
         default:                pins = 3'b111;
      endcase

      res_in.scl_level = pins[0];
      res_in.sda_level = pins[1];
      res_in.sda_drive_enable = pins[2];
      res_in.busy_res = (phase_in != i2cra_pkg::PH_IDLE);
      res_in.done_res = done;
      res_in.read_data = rx_in;
      res_in.nack_seen = nack_in;
      res_in.command_rejected = head.item.is_cmd && (phase_ff != i2cra_pkg::PH_IDLE);

      rsp_valid_in = pop || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= i2cra_pkg::PH_IDLE;
         step_ff <= i2cra_pkg::STEP_ADDR;
         bit_index_ff <= 4'd0;
         ticks_ff <= '0;
         rx_ff <= 8'd0;
         nack_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            phase_ff <= phase_in;
            step_ff <= step_in;
            bit_index_ff <= bit_index_in;
            ticks_ff <= ticks_in;
            rx_ff <= rx_in;
            nack_ff <= nack_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         shift_ff <= shift_in;
         is_read_ff <= is_read_in;
         addr_ff <= addr_in;
         reg_ff <= reg_in;
         data_ff <= data_in;
         res_ff <= res_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.scl_level = res_ff.scl_level;
   assign rsp_chan.sda_level = res_ff.sda_level;
   assign rsp_chan.sda_drive_enable = res_ff.sda_drive_enable;
   assign rsp_chan.busy_res = res_ff.busy_res;
   assign rsp_chan.done_res = res_ff.done_res;
   assign rsp_chan.read_data = res_ff.read_data;
   assign rsp_chan.nack_seen = res_ff.nack_seen;
   assign rsp_chan.command_rejected = res_ff.command_rejected;

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_ff.done_res |-> !res_ff.busy_res)
      else $error("stop completion reported while busy");
   a_idle_pins: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && phase_ff == i2cra_pkg::PH_IDLE |->
      res_ff.scl_level && res_ff.sda_level && res_ff.sda_drive_enable)
      else $error("bus not released while idle");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> rsp_valid_ff && $stable(res_ff))
      else $error("result overwritten while stalled");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register access master testbench
// Drives command and tick words with bursty timing, stalls the result side
// and checks every result word against a word-level model of the bus sequencer.
// It covers register writes and reads, NACKs, rejected commands and several
// phase lengths up to the largest one.
// ----------------------------------------------------------------------------
module tb_top;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int SDA_ACKED = 0;
   localparam int SDA_HIGH  = 1;
   localparam int SDA_LOW   = 2;
   localparam int SDA_NOISE = 3;

   localparam int RX_STEADY = 0;
   localparam int RX_SPARSE = 1;
   localparam int RX_COIN   = 2;
   localparam int RX_BLOCKS = 3;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_WORDS   = 240;

   class bus_scoreboard;
      logic [15:0]              period;
      i2cra_pkg::phase_type     ph;
      logic [3:0]               bit_cnt;
      logic [7:0]               shreg;
      logic [15:0]              tick_cnt;
      i2cra_pkg::byte_step_type step;
      logic                     rd_flag;
      logic [6:0]               addr_q;
      logic [7:0]               reg_q;
      logic [7:0]               data_q;
      logic [7:0]               rx_byte;
      logic                     nack_q;
      i2cra_pkg::result_type    bus_words[$];
      int unsigned              errors;

      function new();
         period   = 16'd1;
         ph       = i2cra_pkg::PH_IDLE;
         bit_cnt  = 4'd0;
         shreg    = 8'd0;
         tick_cnt = 16'd0;
         step     = i2cra_pkg::STEP_ADDR;
         rd_flag  = 1'b0;
         addr_q   = 7'd0;
         reg_q    = 8'd0;
         data_q   = 8'd0;
         rx_byte  = 8'd0;
         nack_q   = 1'b0;
         errors   = 0;
      endfunction

      function int pending();
         return bus_words.size();
      endfunction

      function void note_word(logic [1:0] op, logic [6:0] dev, logic [7:0] regn,
                              logic [7:0] wdat, logic sda);
         i2cra_pkg::result_type want;
         logic                  is_cmd;
         logic [15:0]           lim;
         logic [2:0]            levels;
         is_cmd = (op == i2cra_pkg::OP_WRITE) || (op == i2cra_pkg::OP_READ);
         lim = (period == 16'd0) ? 16'd1 : period;
         want = '0;
         if (ph == i2cra_pkg::PH_IDLE) begin
            if (is_cmd) begin
               addr_q   = dev;
               reg_q    = regn;
               data_q   = wdat;
               rd_flag  = (op == i2cra_pkg::OP_READ);
               step     = i2cra_pkg::STEP_ADDR;
               bit_cnt  = 4'd0;
               nack_q   = 1'b0;
               tick_cnt = 16'd0;
               ph       = i2cra_pkg::PH_ST_SETUP;
            end
         end else begin
            want.command_rejected = is_cmd;
            tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt >= lim || tick_cnt == 16'd0) begin
               tick_cnt = 16'd0;
               case (ph)
                  i2cra_pkg::PH_RS_PRE:   ph = i2cra_pkg::PH_ST_SETUP;
                  i2cra_pkg::PH_ST_SETUP: ph = i2cra_pkg::PH_ST_HOLD;
                  i2cra_pkg::PH_ST_HOLD:  ph = i2cra_pkg::PH_ST_LOW;
                  i2cra_pkg::PH_ST_LOW: begin
                     shreg   = {addr_q, step == i2cra_pkg::STEP_RADDR};
                     bit_cnt = 4'd0;
                     ph      = i2cra_pkg::PH_TX_LOW;
                  end
                  i2cra_pkg::PH_TX_LOW:   ph = i2cra_pkg::PH_TX_HIGH;
                  i2cra_pkg::PH_TX_HIGH: begin
                     shreg   = {shreg[6:0], 1'b0};
                     bit_cnt = bit_cnt + 4'd1;
                     ph      = (bit_cnt >= 4'd8) ? i2cra_pkg::PH_ACK_LOW
                                                 : i2cra_pkg::PH_TX_LOW;
                  end
                  i2cra_pkg::PH_ACK_LOW:  ph = i2cra_pkg::PH_ACK_HIGH;
                  i2cra_pkg::PH_ACK_HIGH: begin
                     if (sda) begin
                        nack_q = 1'b1;
                     end
                     bit_cnt = 4'd0;
                     if (step == i2cra_pkg::STEP_ADDR) begin
                        step  = i2cra_pkg::STEP_REG;
                        shreg = reg_q;
                        ph    = i2cra_pkg::PH_TX_LOW;
                     end else if (step == i2cra_pkg::STEP_REG && !rd_flag) begin
                        step  = i2cra_pkg::STEP_DATA;
                        shreg = data_q;
                        ph    = i2cra_pkg::PH_TX_LOW;
                     end else if (step == i2cra_pkg::STEP_REG) begin
                        step = i2cra_pkg::STEP_RADDR;
                        ph   = i2cra_pkg::PH_RS_PRE;
                     end else if (step == i2cra_pkg::STEP_RADDR) begin
                        shreg = 8'd0;
                        ph    = i2cra_pkg::PH_RX_LOW;
                     end else begin
                        ph = i2cra_pkg::PH_SP_LOW;
                     end
                  end
                  i2cra_pkg::PH_RX_LOW:   ph = i2cra_pkg::PH_RX_HIGH;
                  i2cra_pkg::PH_RX_HIGH: begin
                     shreg   = {shreg[6:0], sda};
                     bit_cnt = bit_cnt + 4'd1;
                     if (bit_cnt >= 4'd8) begin
                        rx_byte = shreg;
                        ph      = i2cra_pkg::PH_MN_LOW;
                     end else begin
                        ph = i2cra_pkg::PH_RX_LOW;
                     end
                  end
                  i2cra_pkg::PH_MN_LOW:   ph = i2cra_pkg::PH_MN_HIGH;
                  i2cra_pkg::PH_MN_HIGH:  ph = i2cra_pkg::PH_SP_LOW;
                  i2cra_pkg::PH_SP_LOW:   ph = i2cra_pkg::PH_SP_HIGH;
                  i2cra_pkg::PH_SP_HIGH:  ph = i2cra_pkg::PH_SP_END;
                  i2cra_pkg::PH_SP_END: begin
                     ph = i2cra_pkg::PH_IDLE;
                     want.done_res = 1'b1;
                  end
                  default:                ph = i2cra_pkg::PH_IDLE;
               endcase
            end
         end
         // Levels are {scl, sda, drive}.
         case (ph)
            i2cra_pkg::PH_RS_PRE:   levels = 3'b011;
            i2cra_pkg::PH_ST_SETUP: levels = 3'b111;
            i2cra_pkg::PH_ST_HOLD:  levels = 3'b101;
            i2cra_pkg::PH_ST_LOW:   levels = 3'b001;
            i2cra_pkg::PH_TX_LOW:   levels = {1'b0, shreg[7], 1'b1};
            i2cra_pkg::PH_TX_HIGH:  levels = {1'b1, shreg[7], 1'b1};
            i2cra_pkg::PH_ACK_LOW:  levels = 3'b010;
            i2cra_pkg::PH_ACK_HIGH: levels = 3'b110;
            i2cra_pkg::PH_RX_LOW:   levels = 3'b010;
            i2cra_pkg::PH_RX_HIGH:  levels = 3'b110;
            i2cra_pkg::PH_MN_LOW:   levels = 3'b011;
            i2cra_pkg::PH_MN_HIGH:  levels = 3'b111;
            i2cra_pkg::PH_SP_LOW:   levels = 3'b001;
            i2cra_pkg::PH_SP_HIGH:  levels = 3'b101;
            default:                levels = 3'b111;
         endcase
         {want.scl_level, want.sda_level, want.sda_drive_enable} = levels;
         want.busy_res  = (ph != i2cra_pkg::PH_IDLE);
         want.read_data = rx_byte;
         want.nack_seen = nack_q;
         bus_words.push_back(want);
      endfunction

      function void compare(string name, logic [7:0] want, logic [7:0] seen);
         if (want !== seen) begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            errors++;
         end
      endfunction

      function void check_word(i2cra_pkg::result_type seen);
         i2cra_pkg::result_type want;
         if (bus_words.size() == 0) begin
            $error("result word arrived with no expectation pending");
            errors++;
         end else begin
            want = bus_words.pop_front();
            compare("scl_level", 8'(want.scl_level), 8'(seen.scl_level));
            compare("sda_level", 8'(want.sda_level), 8'(seen.sda_level));
            compare("sda_drive_enable", 8'(want.sda_drive_enable),
                    8'(seen.sda_drive_enable));
            compare("busy_res", 8'(want.busy_res), 8'(seen.busy_res));
            compare("done_res", 8'(want.done_res), 8'(seen.done_res));
            compare("read_data", want.read_data, seen.read_data);
            compare("nack_seen", 8'(want.nack_seen), 8'(seen.nack_seen));
            compare("command_rejected", 8'(want.command_rejected),
                    8'(seen.command_rejected));
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we;
   logic [15:0] csr_wdata;

   i2cra_req_if req_if ();
   i2cra_rsp_if rsp_if ();

   i2c_register_access_master i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   bus_scoreboard sb = new();
   int            burst_left = 0;
   int unsigned   word_count = 0;
   int unsigned   quiet_cycles = 0;
   logic [7:0]    stall_count = 8'd0;
   int            stall_style = RX_STEADY;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic send_word(logic [1:0] op, logic [6:0] dev, logic [7:0] regn,
                            logic [7:0] wdat, logic sda);
      if (burst_left <= 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 300 : int'($urandom_range(1, 30));
      end
      burst_left--;
      req_if.valid            <= 1'b1;
      req_if.operation        <= op;
      req_if.device_address   <= dev;
      req_if.register_address <= regn;
      req_if.write_data       <= wdat;
      req_if.sda_in           <= sda;
      do @(posedge clock); while (!req_if.ready);
      sb.note_word(op, dev, regn, wdat, sda);
      word_count++;
   endtask

   task automatic run_transaction(logic [1:0] op, logic [6:0] dev, logic [7:0] regn,
                                  logic [7:0] wdat, int policy, int noise_pct,
                                  bit stop_cmd);
      logic       sda;
      logic [1:0] tick_op;
      send_word(op, dev, regn, wdat, 1'($urandom_range(0, 1)));
      while (sb.ph != i2cra_pkg::PH_IDLE) begin
         case (policy)
            SDA_ACKED: begin
               if (sb.ph == i2cra_pkg::PH_ACK_HIGH) begin
                  sda = ($urandom_range(0, 15) == 0);
               end else begin
                  sda = 1'($urandom_range(0, 1));
               end
            end
            SDA_HIGH: sda = 1'b1;
            SDA_LOW:  sda = 1'b0;
            default:  sda = 1'($urandom_range(0, 1));
         endcase
         tick_op = i2cra_pkg::OP_TICK;
         if (int'($urandom_range(0, 99)) < noise_pct) begin
            case ($urandom_range(0, 2))
               0:       tick_op = i2cra_pkg::OP_WRITE;
               1:       tick_op = i2cra_pkg::OP_READ;
               default: tick_op = OP_UNUSED;
            endcase
         end
         if (stop_cmd && sb.ph == i2cra_pkg::PH_SP_END) begin
            tick_op = i2cra_pkg::OP_READ;
         end
         send_word(tick_op, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), sda);
      end
   endtask

   task automatic write_period(logic [15:0] value);
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.period = value;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         stall_count <= stall_count + 8'd1;
         if (stall_count == 8'd0) begin
            stall_style <= $urandom_range(RX_STEADY, RX_BLOCKS);
         end
         case (stall_style)
            RX_STEADY: rsp_if.ready <= 1'b1;
            RX_SPARSE: rsp_if.ready <= (stall_count[1:0] != 2'b11);
            RX_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
            default:   rsp_if.ready <= (stall_count[4:3] != 2'b00);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         sb.check_word({rsp_if.scl_level, rsp_if.sda_level, rsp_if.sda_drive_enable,
                        rsp_if.busy_res, rsp_if.done_res, rsp_if.read_data,
                        rsp_if.nack_seen, rsp_if.command_rejected});
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [15:0] periods [5];
      int unsigned start_count;
      int          pick;
      int          policy;
      periods = '{16'd2, 16'd1, 16'd3, 16'd0, 16'd1};
      req_if.valid            <= 1'b0;
      req_if.operation        <= i2cra_pkg::OP_TICK;
      req_if.device_address   <= 7'd0;
      req_if.register_address <= 8'd0;
      req_if.write_data       <= 8'd0;
      req_if.sda_in           <= 1'b0;
      csr_we                  <= 1'b0;
      csr_wdata               <= 16'd0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed words at the reset phase length, then a write at phase length zero.
      send_word(i2cra_pkg::OP_TICK, 7'h7F, 8'hFF, 8'hFF, 1'b1);
      send_word(OP_UNUSED, 7'h00, 8'h00, 8'h00, 1'b0);
      run_transaction(i2cra_pkg::OP_WRITE, 7'h7F, 8'hFF, 8'h00, SDA_LOW, 30, 1'b0);
      run_transaction(i2cra_pkg::OP_WRITE, 7'h00, 8'h00, 8'hFF, SDA_HIGH, 0, 1'b1);
      run_transaction(i2cra_pkg::OP_READ, 7'h7F, 8'hA5, 8'h00, SDA_HIGH, 0, 1'b0);
      run_transaction(i2cra_pkg::OP_READ, 7'h00, 8'h5A, 8'hFF, SDA_LOW, 30, 1'b1);
      run_transaction(i2cra_pkg::OP_READ, 7'h55, 8'h3C, 8'h81, SDA_ACKED, 0, 1'b0);
      write_period(16'd0);
      run_transaction(i2cra_pkg::OP_WRITE, 7'h2A, 8'hC3, 8'h96, SDA_ACKED, 0, 1'b0);

      foreach (periods[k]) begin
         write_period(periods[k]);
         start_count = word_count;
         while (word_count - start_count < RANDOM_WORDS) begin
            pick = $urandom_range(0, 9);
            if (pick < 8) begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4, 5: policy = SDA_ACKED;
                  6:                policy = SDA_HIGH;
                  7:                policy = SDA_LOW;
                  default:          policy = SDA_NOISE;
               endcase
               run_transaction(($urandom_range(0, 1) == 0) ? i2cra_pkg::OP_WRITE
                                                           : i2cra_pkg::OP_READ,
                               7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), policy,
                               ($urandom_range(0, 1) == 0) ? 0 : 10,
                               ($urandom_range(0, 3) == 0));
            end else begin
               repeat ($urandom_range(1, 5)) begin
                  send_word(($urandom_range(0, 1) == 0) ? i2cra_pkg::OP_TICK : OP_UNUSED,
                            7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
               end
            end
         end
      end

      // Longest phase: one transaction held in its first phase.
      write_period(16'hFFFF);
      send_word(i2cra_pkg::OP_WRITE, 7'($urandom_range(0, 127)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
      repeat (40) begin
         send_word(($urandom_range(0, 9) == 0) ? i2cra_pkg::OP_READ : i2cra_pkg::OP_TICK,
                   7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end

      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
